// ===== sv/bmf_pkg.sv =====
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared constants, codes and types of the broadcast masked fill unit.
// ----------------------------------------------------------------------------
package bmf_pkg;

	localparam int MAX_DIMS       = 8;
	localparam int MASK_ENTRIES   = 4096;
	localparam int SIZE_BITS      = 16;

	localparam int MASK_ADDR_W    = $clog2(MASK_ENTRIES);
	localparam int DIM_IDX_W      = $clog2(MAX_DIMS);
	localparam int DIM_CNT_W      = 4;
	localparam int VALUE_W        = 32;
	localparam int HALF_W         = 16;
	localparam int CFG_DATA_W     = 64;
	localparam int CFG_INDEX_W    = 3;
	localparam int SIZE_FIELD_W   = 16;
	localparam int SIZES_PER_WORD = 4;
	localparam int LOCATION_W     = 12;
	localparam int COMMAND_W      = 2;

	localparam logic [CFG_DATA_W-1:0] SIZES_RESET = 64'h0001_0001_0001_0001;

	typedef enum logic [COMMAND_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_DATA    = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DIM_COUNT   = 3'd0,
		REG_SIZES_OUTER = 3'd1,
		REG_SIZES_INNER = 3'd2,
		REG_BCAST_FLAGS = 3'd3,
		REG_FILL_VALUE  = 3'd4,
		REG_HALF_PREC   = 3'd5
	} cfg_reg_t;

	typedef logic [SIZE_BITS-1:0]   size_t;
	typedef logic [MASK_ADDR_W-1:0] maddr_t;

	// Tensor shape as seen by the coordinate unit
	typedef struct packed {
		logic [DIM_CNT_W-1:0]      dims_used;
		size_t [MAX_DIMS-1:0]      sizes;
		logic [MAX_DIMS-1:0]       bcast;
	} geom_t;

	// Coordinate unit status toward the datapath
	typedef struct packed {
		logic   busy;
		logic   last;
		maddr_t addr;
	} coord_stat_t;

endpackage

// ===== sv/bmf_if.sv =====
// ----------------------------------------------------------------------------
// bmf_in_if / bmf_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface bmf_in_if import bmf_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [COMMAND_W-1:0]   command;
	logic [LOCATION_W-1:0]  mask_location;
	logic                   mask_bit;
	logic [VALUE_W-1:0]     element_value;

	modport source (output valid, command, mask_location, mask_bit, element_value,
		input ready);
	modport sink (input valid, command, mask_location, mask_bit, element_value,
		output ready);
endinterface

interface bmf_out_if import bmf_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [VALUE_W-1:0]     output_value;
	logic                   was_masked;
	logic                   final_element;

	modport source (output valid, output_value, was_masked, final_element,
		input ready);
	modport sink (input valid, output_value, was_masked, final_element,
		output ready);
endinterface

// ===== sv/bmf_mask_ram.sv =====
// ----------------------------------------------------------------------------
// bmf_mask_ram
// Single-port mask store, one bit per entry, registered read data.
// ----------------------------------------------------------------------------
module bmf_mask_ram import bmf_pkg::*; (
	input  logic   clk,
	input  logic   we,
	input  logic   re,
	input  maddr_t addr,
	input  logic   wdata,
	output logic   rdata
);

	logic mem [MASK_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		// hold read data until the next read
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== sv/bmf_coord_unit.sv =====
// ----------------------------------------------------------------------------
// bmf_coord_unit
// Per-dimension coordinate counters with per-dimension mask address terms;
// recomputes strides and address terms after reset and each config write.
// ----------------------------------------------------------------------------
module bmf_coord_unit import bmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  geom_t       geom,
	input  logic        sweep_start,
	input  logic        step,
	input  logic        restart,
	output coord_stat_t stat
);

	size_t                  coord_q   [MAX_DIMS];
	maddr_t                 contrib_q [MAX_DIMS];
	maddr_t                 stride_q  [MAX_DIMS];
	maddr_t                 run_q;
	logic                   busy_q;
	logic [DIM_IDX_W-1:0]   sweep_dim_q;

	logic [MAX_DIMS-1:0]    used;
	logic [MAX_DIMS-1:0]    active;
	logic [MAX_DIMS-1:0]    wrap;
	logic [MAX_DIMS-1:0]    inc;
	logic                   carry;
	maddr_t                 addr_sum;
	size_t                  sweep_size;
	logic [2*MASK_ADDR_W-1:0] run_prod;
	logic [2*MASK_ADDR_W-1:0] contrib_prod;

	always_comb begin
		carry    = 1'b1;
		addr_sum = '0;
		for (int j = 0; j < MAX_DIMS; j++) begin
			used[j]   = DIM_CNT_W'(j) < geom.dims_used;
			active[j] = used[j] && !geom.bcast[j];
			wrap[j]   = ({1'b0, coord_q[j]} + (SIZE_BITS+1)'(1)) >= {1'b0, geom.sizes[j]};
			if (active[j]) begin
				addr_sum = addr_sum + contrib_q[j];
			end
		end
		// ripple the carry from the fastest dimension outward
		for (int j = MAX_DIMS - 1; j >= 0; j--) begin
			inc[j] = used[j] && carry;
			if (used[j]) begin
				carry = carry && wrap[j];
			end
		end
	end

	assign sweep_size   = geom.sizes[sweep_dim_q];
	assign run_prod     = (2*MASK_ADDR_W)'(run_q) * (2*MASK_ADDR_W)'(maddr_t'(sweep_size));
	assign contrib_prod = (2*MASK_ADDR_W)'(maddr_t'(coord_q[sweep_dim_q]))
		* (2*MASK_ADDR_W)'(run_q);

	assign stat.busy = busy_q;
	assign stat.last = carry;
	assign stat.addr = addr_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b1;
			sweep_dim_q <= DIM_IDX_W'(MAX_DIMS - 1);
			run_q       <= maddr_t'(1);
		end else if (sweep_start) begin
			busy_q      <= 1'b1;
			sweep_dim_q <= DIM_IDX_W'(MAX_DIMS - 1);
			run_q       <= maddr_t'(1);
		end else if (busy_q) begin
			if (active[sweep_dim_q]) begin
				run_q <= run_prod[MASK_ADDR_W-1:0];
			end
			if (sweep_dim_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				sweep_dim_q <= sweep_dim_q - DIM_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			stride_q[sweep_dim_q] <= run_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_DIMS; j++) begin
				coord_q[j]   <= '0;
				contrib_q[j] <= '0;
			end
		end else if (restart || (step && carry)) begin
			for (int j = 0; j < MAX_DIMS; j++) begin
				coord_q[j]   <= '0;
				contrib_q[j] <= '0;
			end
		end else if (step) begin
			for (int j = 0; j < MAX_DIMS; j++) begin
				if (inc[j]) begin
					if (wrap[j]) begin
						coord_q[j]   <= '0;
						contrib_q[j] <= '0;
					end else begin
						coord_q[j]   <= coord_q[j] + size_t'(1);
						contrib_q[j] <= contrib_q[j] + stride_q[j];
					end
				end
			end
		end else if (busy_q) begin
			contrib_q[sweep_dim_q] <= contrib_prod[MASK_ADDR_W-1:0];
		end
	end

endmodule

// ===== sv/broadcast_masked_fill_unit.sv =====
// ----------------------------------------------------------------------------
// broadcast_masked_fill_unit
// Masked fill over a row-major tensor of up to eight dimensions with a
// broadcasting mask held in an on-chip mask store.
// ----------------------------------------------------------------------------
// The unit accepts one item per clock while it is not rebuilding strides and
// the output is not stalled. A mask load writes the mask store and a restart
// clears the coordinates, neither gives a result; a data element passes the
// registered mask store read and then the output register before its result
// appears, and results follow back to back while the receiver is ready. The
// mask address comes from per-dimension address terms kept next to the
// coordinate counters, so each element costs only a short add tree and the
// counter carry. After reset and after every configuration write the unit
// holds ready low while it walks the dimensions once to rebuild strides and
// address terms, two small multiplies per dimension.
module broadcast_masked_fill_unit import bmf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	bmf_in_if.sink                 in_ch,
	bmf_out_if.source              out_ch,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [DIM_CNT_W-1:0]   dim_count_q;
	logic [CFG_DATA_W-1:0]  sizes_outer_q;
	logic [CFG_DATA_W-1:0]  sizes_inner_q;
	logic [MAX_DIMS-1:0]    bcast_q;
	logic [VALUE_W-1:0]     fill_q;
	logic                   half_q;

	geom_t                  geom;
	coord_stat_t            stat;

	logic                   accept;
	logic                   data_acc;
	logic                   load_acc;
	logic                   restart_acc;
	logic                   s1_adv;
	logic                   mask_rd;
	maddr_t                 ram_addr;

	logic                   valid_s1;
	logic [VALUE_W-1:0]     elem_s1;
	logic                   last_s1;
	logic                   mask_bit_s1;

	logic                   out_valid_q;
	logic [VALUE_W-1:0]     out_value_q;
	logic                   out_masked_q;
	logic                   out_last_q;
	logic [VALUE_W-1:0]     picked;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q   <= DIM_CNT_W'(1);
			sizes_outer_q <= SIZES_RESET;
			sizes_inner_q <= SIZES_RESET;
			bcast_q       <= '0;
			fill_q        <= '0;
			half_q        <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DIM_COUNT:   dim_count_q   <= cfg_data[DIM_CNT_W-1:0];
				REG_SIZES_OUTER: sizes_outer_q <= cfg_data;
				REG_SIZES_INNER: sizes_inner_q <= cfg_data;
				REG_BCAST_FLAGS: bcast_q       <= cfg_data[MAX_DIMS-1:0];
				REG_FILL_VALUE:  fill_q        <= cfg_data[VALUE_W-1:0];
				REG_HALF_PREC:   half_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp the dimension count and unpack sizes, zero read as one
	always_comb begin
		if (dim_count_q == '0) begin
			geom.dims_used = DIM_CNT_W'(1);
		end else if (dim_count_q > DIM_CNT_W'(MAX_DIMS)) begin
			geom.dims_used = DIM_CNT_W'(MAX_DIMS);
		end else begin
			geom.dims_used = dim_count_q;
		end
		for (int j = 0; j < MAX_DIMS; j++) begin
			if (j < SIZES_PER_WORD) begin
				geom.sizes[j] = sizes_outer_q[SIZE_FIELD_W*(j % SIZES_PER_WORD) +: SIZE_BITS];
			end else begin
				geom.sizes[j] = sizes_inner_q[SIZE_FIELD_W*(j % SIZES_PER_WORD) +: SIZE_BITS];
			end
			if (geom.sizes[j] == '0) begin
				geom.sizes[j] = size_t'(1);
			end
		end
		geom.bcast = bcast_q;
	end

	assign s1_adv       = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = !stat.busy && (!valid_s1 || s1_adv);
	assign accept       = in_ch.valid && in_ch.ready;
	assign data_acc     = accept && (in_ch.command == CMD_DATA);
	assign load_acc     = accept && (in_ch.command == CMD_LOAD);
	assign restart_acc  = accept && (in_ch.command == CMD_RESTART);
	assign mask_rd      = data_acc;
	assign ram_addr     = load_acc ? maddr_t'(in_ch.mask_location) : stat.addr;

	bmf_coord_unit u_coord (
		.clk         (clk),
		.arst_n      (arst_n),
		.geom        (geom),
		.sweep_start (cfg_we),
		.step        (data_acc),
		.restart     (restart_acc),
		.stat        (stat)
	);

	bmf_mask_ram u_mask_ram (
		.clk   (clk),
		.we    (load_acc),
		.re    (mask_rd),
		.addr  (ram_addr),
		.wdata (in_ch.mask_bit),
		.rdata (mask_bit_s1)
	);

	// Stage 1: element waits beside the mask read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_acc) begin
			elem_s1 <= in_ch.element_value;
			last_s1 <= stat.last;
		end
	end

	always_comb begin
		picked = mask_bit_s1 ? fill_q : elem_s1;
		if (half_q) begin
			picked = {{(VALUE_W-HALF_W){1'b0}}, picked[HALF_W-1:0]};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			out_value_q  <= picked;
			out_masked_q <= mask_bit_s1;
			out_last_q   <= last_s1;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.output_value  = out_value_q;
	assign out_ch.was_masked    = out_masked_q;
	assign out_ch.final_element = out_last_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !in_ch.ready)
		else $error("item accepted during stride rebuild");

	a_data_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		data_acc |=> valid_s1)
		else $error("accepted element lost before stage 1");

	a_wrap_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		data_acc && stat.last |=> stat.addr == '0)
		else $error("mask address not zero after final element");

	a_s1_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |=> out_valid_q)
		else $error("stage 1 item did not move to empty output");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the broadcast masked fill unit against a cycle-free predictor of
// its coordinate walk, broadcast mask addressing and fill selection. Mask
// entries are loaded before any element reads them. The stimulus runs a
// short directed opening, then random phases over several tensor shapes,
// with sender gaps and receiver stalls varied from phase to phase.
// ----------------------------------------------------------------------------
module testbench import bmf_pkg::*; ;

	localparam logic [COMMAND_W-1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int SETTLE_CYCLES   = 4;
	localparam int TAIL_CYCLES     = 10;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 133;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               masked;
		logic               last;
	} fill_result_t;

	class fill_scoreboard;
		logic [DIM_CNT_W-1:0]  dim_count;
		logic [CFG_DATA_W-1:0] sizes_outer;
		logic [CFG_DATA_W-1:0] sizes_inner;
		logic [MAX_DIMS-1:0]   bcast;
		logic [VALUE_W-1:0]    fill;
		logic                  half;
		size_t                 coord [MAX_DIMS];
		bit                    mask_bits [MASK_ENTRIES];
		bit                    mask_written [MASK_ENTRIES];
		fill_result_t          expected_q [$];
		int                    errors;
		int                    results;

		function new();
			dim_count   = DIM_CNT_W'(1);
			sizes_outer = SIZES_RESET;
			sizes_inner = SIZES_RESET;
			bcast       = '0;
			fill        = '0;
			half        = 1'b0;
			errors      = 0;
			results     = 0;
			foreach (coord[j]) coord[j] = '0;
		endfunction

		function void write_reg(cfg_reg_t index, logic [CFG_DATA_W-1:0] data);
			case (index)
				REG_DIM_COUNT:   dim_count = data[DIM_CNT_W-1:0];
				REG_SIZES_OUTER: sizes_outer = data;
				REG_SIZES_INNER: sizes_inner = data;
				REG_BCAST_FLAGS: bcast = data[MAX_DIMS-1:0];
				REG_FILL_VALUE:  fill = data[VALUE_W-1:0];
				REG_HALF_PREC:   half = data[0];
				default: ;
			endcase
		endfunction

		function int dims_used();
			int n;
			n = int'(dim_count);
			if (n == 0) n = 1;
			if (n > MAX_DIMS) n = MAX_DIMS;
			return n;
		endfunction

		function int dim_size(int j);
			logic [CFG_DATA_W-1:0] word;
			int s;
			word = (j < SIZES_PER_WORD) ? sizes_outer : sizes_inner;
			s = int'(word[SIZE_FIELD_W*(j % SIZES_PER_WORD) +: SIZE_FIELD_W]);
			return (s == 0) ? 1 : s;
		endfunction

		// Row-major offset within the mask tensor; broadcast dims add nothing
		function maddr_t element_addr();
			maddr_t addr;
			maddr_t stride;
			int j;
			addr = '0;
			stride = maddr_t'(1);
			for (j = dims_used() - 1; j >= 0; j--) begin
				if (!bcast[j]) begin
					addr = addr + maddr_t'(stride * coord[j]);
					stride = maddr_t'(stride * dim_size(j));
				end
			end
			return addr;
		endfunction

		function void clear_coords();
			foreach (coord[j]) coord[j] = '0;
		endfunction

		function void note_item(logic [COMMAND_W-1:0] command, logic [LOCATION_W-1:0] location,
			logic mbit, logic [VALUE_W-1:0] value);
			fill_result_t r;
			maddr_t addr;
			bit carry;
			int j;
			case (command)
				CMD_LOAD: begin
					mask_bits[location] = mbit;
					mask_written[location] = 1'b1;
				end
				CMD_RESTART: clear_coords();
				CMD_DATA: begin
					addr = element_addr();
					r.masked = mask_bits[addr];
					r.value = r.masked ? fill : value;
					if (half) r.value[VALUE_W-1:HALF_W] = '0;
					// A coordinate past its size wraps like one at its last position
					carry = 1'b1;
					for (j = dims_used() - 1; j >= 0 && carry; j--) begin
						if (int'(coord[j]) + 1 >= dim_size(j)) begin
							coord[j] = '0;
						end else begin
							coord[j] = coord[j] + size_t'(1);
							carry = 1'b0;
						end
					end
					if (carry) clear_coords();
					r.last = carry;
					expected_q.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string what);
			errors++;
			$display("ERROR at %0t: %s", $time, what);
		endtask

		task check_result(logic [VALUE_W-1:0] value, logic masked, logic last);
			fill_result_t want;
			results++;
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d arrived with nothing outstanding", results));
				return;
			end
			want = expected_q.pop_front();
			if (value !== want.value)
				report($sformatf("result %0d output_value %h, want %h", results, value,
					want.value));
			if (masked !== want.masked)
				report($sformatf("result %0d was_masked %b, want %b", results, masked,
					want.masked));
			if (last !== want.last)
				report($sformatf("result %0d final_element %b, want %b", results, last,
					want.last));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     cycles = 0;
	int                     send_idle = 0;
	int                     stall_pct = 0;
	int                     sent = 0;
	fill_scoreboard         sb = new();

	bmf_in_if  in_ch();
	bmf_out_if out_ch();

	broadcast_masked_fill_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Result side: check each accepted item, then pick next cycle's ready
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready)
				sb.check_result(out_ch.output_value, out_ch.was_masked, out_ch.final_element);
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic [VALUE_W-1:0] random_value();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] sizes4(int a, int b, int c, int d);
		return {16'(d), 16'(c), 16'(b), 16'(a)};
	endfunction

	function automatic int random_size();
		return ($urandom_range(15) == 0) ? 16'hFFFF : $urandom_range(4);
	endfunction

	function automatic logic [LOCATION_W-1:0] random_location();
		return LOCATION_W'($urandom_range(MASK_ENTRIES - 1));
	endfunction

	function automatic logic random_bit();
		return 1'($urandom_range(1));
	endfunction

	task automatic put_item(logic [COMMAND_W-1:0] command, logic [LOCATION_W-1:0] location,
		logic mbit, logic [VALUE_W-1:0] value);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.command       <= command;
		in_ch.mask_location <= location;
		in_ch.mask_bit      <= mbit;
		in_ch.element_value <= value;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.note_item(command, location, mbit, value);
		sent++;
	endtask

	// Load the mask entry first if the next element would read it unwritten
	task automatic put_data(logic [VALUE_W-1:0] value);
		maddr_t addr;
		addr = sb.element_addr();
		if (!sb.mask_written[addr])
			put_item(CMD_LOAD, addr, random_bit(), $urandom);
		put_item(CMD_DATA, random_location(), random_bit(), value);
	endtask

	// Every accepted item counts toward the phase, loads ahead of data too
	task automatic random_items(int count);
		int stop;
		int pick;
		stop = sent + count;
		while (sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				put_data(random_value());
			end else if (pick < 82) begin
				put_item(CMD_LOAD, random_location(), random_bit(), $urandom);
			end else if (pick < 94) begin
				// rewrite the entry the next element will read
				put_item(CMD_LOAD, sb.element_addr(), random_bit(), $urandom);
			end else if (pick < 97) begin
				put_item(CMD_RESTART, random_location(), random_bit(), $urandom);
			end else begin
				put_item(CMD_UNUSED, random_location(), random_bit(), $urandom);
			end
		end
	endtask

	// Narrow registers get random bits above their width
	task automatic write_reg(cfg_reg_t index, logic [CFG_DATA_W-1:0] value, int width);
		logic [CFG_DATA_W-1:0] keep;
		logic [CFG_DATA_W-1:0] data;
		keep = (64'd1 << width) - 64'd1;
		data = ({$urandom, $urandom} & ~keep) | (value & keep);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(index, data);
	endtask

	task automatic set_shape(int n, logic [CFG_DATA_W-1:0] outer, logic [CFG_DATA_W-1:0] inner,
		logic [MAX_DIMS-1:0] flags, logic [VALUE_W-1:0] fill_v, bit half_v);
		// hold the sender until every result is in, then let the pipe empty
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_DIM_COUNT, CFG_DATA_W'(n), DIM_CNT_W);
		write_reg(REG_SIZES_OUTER, outer, CFG_DATA_W);
		write_reg(REG_SIZES_INNER, inner, CFG_DATA_W);
		write_reg(REG_BCAST_FLAGS, CFG_DATA_W'(flags), MAX_DIMS);
		write_reg(REG_FILL_VALUE, CFG_DATA_W'(fill_v), VALUE_W);
		write_reg(REG_HALF_PREC, CFG_DATA_W'(half_v), 1);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int phase;
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= REG_DIM_COUNT;
		cfg_data            <= '0;
		in_ch.valid         <= 1'b0;
		in_ch.command       <= CMD_LOAD;
		in_ch.mask_location <= '0;
		in_ch.mask_bit      <= 1'b0;
		in_ch.element_value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset shape: one dimension of size one, every element is the last
		put_item(CMD_LOAD, '0, 1'b1, '0);
		put_data('1);
		put_item(CMD_LOAD, '0, 1'b0, '1);
		put_data('1);
		put_data('0);
		put_item(CMD_UNUSED, '1, 1'b1, '1);
		put_item(CMD_RESTART, '1, 1'b1, '1);
		put_item(CMD_LOAD, '1, 1'b1, 32'h5555_5555);
		put_data(32'hAAAA_AAAA);

		// Zero-size outer dim, broadcast middle dim; restart partway through
		set_shape(3, sizes4(0, 3, 2, 1), sizes4(1, 1, 1, 1), 8'b0000_0010,
			32'h7FC0_0001, 1'b0);
		repeat (4) put_data($urandom);
		put_item(CMD_RESTART, '0, 1'b0, '0);
		repeat (8) put_data(random_value());

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0: begin send_idle = 0;  stall_pct = 0;  end
				1: begin send_idle = 50; stall_pct = 0;  end
				2: begin send_idle = 0;  stall_pct = 50; end
				default: begin send_idle = 32; stall_pct = 32; end
			endcase
			case (phase)
				0: set_shape(8, sizes4(2, 3, 2, 2), sizes4(3, 2, 2, 2), 8'b1010_0101, '1, 1'b1);
				1: set_shape(0, sizes4(7, 9, 9, 9), sizes4(9, 9, 9, 9), 8'hFF, '0, 1'b0);
				2: set_shape(15, '1, '1, 8'h00, $urandom, 1'b0);
				3: set_shape(2, sizes4(5, 4, 0, 0), '0, 8'h00, $urandom, 1'b1);
				// shrink while coordinates may sit past the new sizes
				4: set_shape(2, sizes4(2, 2, 0, 0), '0, 8'h00, $urandom, 1'b0);
				5: set_shape(4, sizes4(1, 16'hFFFF, 3, 2), sizes4(1, 1, 1, 1), 8'b0000_1000,
					$urandom, 1'b0);
				default: set_shape($urandom_range(15),
					sizes4(random_size(), random_size(), random_size(), random_size()),
					sizes4(random_size(), random_size(), random_size(), random_size()),
					MAX_DIMS'($urandom_range(255)), $urandom, random_bit());
			endcase
			random_items(ITEMS_PER_PHASE);
		end

		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
